// File: rtl/pfw_pkg.sv
package pfw_pkg;

    // default panel geometry in pixels
    localparam int DEFAULT_PANEL_WIDTH  = 192;
    localparam int DEFAULT_PANEL_HEIGHT = 64;

    // address width that covers the largest store (256 columns by 32 pages)
    localparam int MAX_ADDR_W = 13;

    // input operation codes
    typedef enum logic [1:0] {
        OP_DRAW  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    // pixel actions
    typedef enum logic [1:0] {
        COL_CLEAR  = 2'd0,
        COL_SET    = 2'd1,
        COL_TOGGLE = 2'd2,
        COL_KEEP   = 2'd3
    } colour_t;

    // display rotation
    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    // work kinds passed from front to back
    typedef enum logic [1:0] {
        KIND_DRAW  = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    // one queued command
    typedef struct packed {
        kind_t                  kind;
        logic [MAX_ADDR_W-1:0]  addr;
        logic [2:0]             bit_sel;
        colour_t                action;
        logic                   zero;
    } cmd_t;

endpackage

// File: rtl/pfw_ram.sv
module pfw_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/pfw_queue.sv
module pfw_queue
    import pfw_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty,
    output logic full
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign empty    = (count_reg == 2'd0);
    assign full     = (count_reg == 2'd2);
    assign head_cmd = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/pfw_front.sv
module pfw_front
    import pfw_pkg::*;
#(
    parameter int PANEL_WIDTH  = DEFAULT_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEFAULT_PANEL_HEIGHT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_rotation,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic signed [15:0] s_x_coord,
    input  logic signed [15:0] s_y_coord,
    input  logic [1:0]         s_colour,
    input  logic [10:0]        s_byte_index,
    input  logic               init_done,
    input  logic               queue_full,
    output logic               push,
    output cmd_t               push_cmd
);

    localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;

    rot_t        rotation_reg;
    logic [15:0] xu;
    logic [15:0] yu;
    logic [15:0] lw;
    logic [15:0] lh;
    logic        in_range;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] lin_addr;
    logic        read_ok;
    logic        keep;

    assign cfg_ready = 1'b1;
    assign s_ready   = init_done && !queue_full;
    assign xu        = $unsigned(s_x_coord);
    assign yu        = $unsigned(s_y_coord);

    // rotation register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg <= ROT_0;
        end else if (cfg_valid) begin
            rotation_reg <= rot_t'(cfg_rotation);
        end
    end

    // logical bounds swap for quarter turns
    always_comb begin
        if (rotation_reg == ROT_90 || rotation_reg == ROT_270) begin
            lw = 16'(PANEL_HEIGHT);
            lh = 16'(PANEL_WIDTH);
        end else begin
            lw = 16'(PANEL_WIDTH);
            lh = 16'(PANEL_HEIGHT);
        end
    end

    assign in_range = !s_x_coord[15] && !s_y_coord[15] && (xu < lw) && (yu < lh);

    // map logical to physical column and row
    always_comb begin
        case (rotation_reg)
            ROT_90: begin
                px = 16'(PANEL_WIDTH - 1) - yu;
                py = xu;
            end
            ROT_180: begin
                px = 16'(PANEL_WIDTH - 1) - xu;
                py = 16'(PANEL_HEIGHT - 1) - yu;
            end
            ROT_270: begin
                px = yu;
                py = 16'(PANEL_HEIGHT - 1) - xu;
            end
            default: begin
                px = xu;
                py = yu;
            end
        endcase
    end

    // page times width plus column
    assign lin_addr = 16'(PANEL_WIDTH) * (py >> 3) + px;
    assign read_ok  = (32'(s_byte_index) < STORE_BYTES);

    // classify the item and build the queued command
    always_comb begin
        push_cmd.kind    = KIND_DRAW;
        push_cmd.addr    = MAX_ADDR_W'(lin_addr);
        push_cmd.bit_sel = py[2:0];
        push_cmd.action  = colour_t'(s_colour);
        push_cmd.zero    = 1'b0;
        keep             = 1'b0;
        case (op_t'(s_op))
            OP_DRAW: begin
                keep = in_range && (colour_t'(s_colour) != COL_KEEP);
            end
            OP_CLEAR: begin
                push_cmd.kind = KIND_CLEAR;
                keep          = 1'b1;
            end
            OP_READ: begin
                push_cmd.kind = KIND_READ;
                push_cmd.addr = MAX_ADDR_W'(s_byte_index);
                push_cmd.zero = !read_ok;
                keep          = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = s_valid && s_ready && keep;

endmodule

// File: rtl/pfw_back.sv
module pfw_back
    import pfw_pkg::*;
#(
    parameter int PANEL_WIDTH  = DEFAULT_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEFAULT_PANEL_HEIGHT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       head_cmd,
    input  logic       queue_empty,
    output logic       pop,
    output logic       init_done,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_page_byte
);

    localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_MODIFY,
        S_READOUT
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [ADDR_W-1:0] sweep_reg;
    logic [ADDR_W-1:0] sweep_next;
    logic              init_done_reg;
    logic              init_done_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [7:0]        m_byte_reg;
    logic [7:0]        m_byte_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [2:0]        bit_reg;
    logic [2:0]        bit_next;
    colour_t           action_reg;
    colour_t           action_next;
    logic              zero_reg;
    logic              zero_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [7:0]        ram_rdata;
    logic [7:0]        mask;
    logic [7:0]        modified;

    assign init_done   = init_done_reg;
    assign m_valid     = m_valid_reg;
    assign m_page_byte = m_byte_reg;

    // take the head when its result has somewhere to go
    assign pop = (state_reg == S_IDLE) && !queue_empty
                 && (head_cmd.kind != KIND_READ || !m_valid_reg || m_ready);
    assign ram_re = pop && (head_cmd.kind == KIND_DRAW
                            || (head_cmd.kind == KIND_READ && !head_cmd.zero));

    // bit update of the fetched byte
    assign mask = 8'd1 << bit_reg;
    always_comb begin
        case (action_reg)
            COL_CLEAR:  modified = ram_rdata & ~mask;
            COL_SET:    modified = ram_rdata | mask;
            COL_TOGGLE: modified = ram_rdata ^ mask;
            default:    modified = ram_rdata;
        endcase
    end

    // write port: sweep zeros or write back the modified byte
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = modified;
        if (state_reg == S_SWEEP) begin
            ram_we    = 1'b1;
            ram_waddr = sweep_reg;
            ram_wdata = 8'h00;
        end else if (state_reg == S_MODIFY) begin
            ram_we = 1'b1;
        end
    end

    // sequencer next state
    always_comb begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        init_done_next = init_done_reg;
        addr_next      = addr_reg;
        bit_next       = bit_reg;
        action_next    = action_reg;
        zero_next      = zero_reg;
        m_byte_next    = m_byte_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        case (state_reg)
            S_SWEEP: begin
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_reg == ADDR_W'(STORE_BYTES - 1)) begin
                    state_next     = S_IDLE;
                    init_done_next = 1'b1;
                end
            end
            S_IDLE: begin
                if (pop) begin
                    addr_next   = head_cmd.addr[ADDR_W-1:0];
                    bit_next    = head_cmd.bit_sel;
                    action_next = head_cmd.action;
                    zero_next   = head_cmd.zero;
                    case (head_cmd.kind)
                        KIND_DRAW: begin
                            state_next = S_MODIFY;
                        end
                        KIND_CLEAR: begin
                            state_next = S_SWEEP;
                            sweep_next = '0;
                        end
                        KIND_READ: begin
                            state_next = S_READOUT;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MODIFY: begin
                state_next = S_IDLE;
            end
            S_READOUT: begin
                m_valid_next = 1'b1;
                m_byte_next  = zero_reg ? 8'h00 : ram_rdata;
                state_next   = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_SWEEP;
            sweep_reg     <= '0;
            init_done_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            init_done_reg <= init_done_next;
            m_valid_reg   <= m_valid_next;
        end
        m_byte_reg <= m_byte_next;
        addr_reg   <= addr_next;
        bit_reg    <= bit_next;
        action_reg <= action_next;
        zero_reg   <= zero_next;
    end

    // frame store
    pfw_ram #(
        .DATA_W (8),
        .DEPTH  (STORE_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_cmd.addr[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

endmodule

// File: rtl/page_framebuffer_pixel_writer.sv
// Monochrome page frame store of PANEL_WIDTH columns by PANEL_HEIGHT rows, one byte per
// column and 8-row page, with a rotated pixel writer. A draw in the back end fetches the
// byte from the single store RAM and then writes it back, a read fetches the byte and
// then loads the output register, and a clear walks the store one byte a cycle,
// PANEL_WIDTH * ceil(PANEL_HEIGHT/8) bytes, 1536 at the default size.
// The same walk runs after reset, and s_ready stays low until it is done. Draws that
// fall off the rotated panel, colour "no change" and unused op codes are accepted and
// dropped. A two-entry queue sits between the input classifier and the store
// sequencer, so input transfers continue while a result waits on m_ready. The user must
// write rotation through the cfg port only while the block is idle; it is not enforced.
module page_framebuffer_pixel_writer
    import pfw_pkg::*;
#(
    parameter int PANEL_WIDTH  = DEFAULT_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEFAULT_PANEL_HEIGHT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_rotation,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic signed [15:0] s_x_coord,
    input  logic signed [15:0] s_y_coord,
    input  logic [1:0]         s_colour,
    input  logic [10:0]        s_byte_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_page_byte
);

    logic init_done;
    logic queue_full;
    logic queue_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // input classification and coordinate mapping
    pfw_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_rotation (cfg_rotation),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_x_coord    (s_x_coord),
        .s_y_coord    (s_y_coord),
        .s_colour     (s_colour),
        .s_byte_index (s_byte_index),
        .init_done    (init_done),
        .queue_full   (queue_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    // command queue
    pfw_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    // store sequencer and result register
    pfw_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_cmd    (head_cmd),
        .queue_empty (queue_empty),
        .pop         (pop),
        .init_done   (init_done),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_page_byte (m_page_byte)
    );

endmodule
